// ===== src/assert_macros.svh =====
// Assertion macros shared by the occurrence table RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define VOT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked property that is also checked during reset.
`define VOT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/vot_pkg.sv =====
// Package for the variable occurrence table: sizes, codes and entry type.
// Depends on nothing; used by the interfaces and the top level.
package vot_pkg;

    localparam int MAX_VARIABLES     = 65536;
    localparam int CLAUSE_INDEX_BITS = 20;

    localparam int CMD_W    = 2;
    localparam int LIT_W    = 17;
    localparam int CLAUSE_W = 20;
    localparam int STATE_W  = 2;
    localparam int IDX_W    = $clog2(MAX_VARIABLES);
    localparam int ENTRY_W  = STATE_W + CLAUSE_INDEX_BITS;

    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_MARK   = 2'd2
    } t_cmd;

    typedef enum logic [STATE_W-1:0] {
        ST_NONE = 2'd0,
        ST_ONCE = 2'd1,
        ST_MORE = 2'd2,
        ST_MARK = 2'd3
    } t_usage;

    typedef logic [CLAUSE_INDEX_BITS-1:0] t_clause;
    typedef logic [IDX_W-1:0]             t_idx;

    typedef struct packed {
        t_usage  st;
        t_clause cl;
    } t_entry;

endpackage

// ===== src/vot_if.sv =====
// Valid/ready channel interfaces for the occurrence table items.
// Depends on vot_pkg.
interface vot_in_if;
    import vot_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [CMD_W-1:0]            cmd;
    logic signed [LIT_W-1:0]     literal;
    logic [CLAUSE_W-1:0]         clause_index;

    modport source (output valid, output cmd, output literal, output clause_index,
                    input ready);
    modport sink   (input valid, input cmd, input literal, input clause_index,
                    output ready);
endinterface

interface vot_out_if;
    import vot_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        removable;
    logic signed [LIT_W-1:0]     literal_echo;
    logic [STATE_W-1:0]          usage_state;

    modport source (output valid, output removable, output literal_echo,
                    output usage_state, input ready);
    modport sink   (input valid, input removable, input literal_echo,
                    input usage_state, output ready);
endinterface

// ===== src/variable_occurrence_table_core.sv =====
// Top level of the variable occurrence table: one RAM of usage entries,
// read-modify-write pipeline with bypass, output register.
// Depends on vot_pkg, vot_if (vot_in_if, vot_out_if), vot_ram, assert_macros.svh.
//
//   channel   dir  handshake          payload
//   i_in      in   valid/ready        cmd, literal, clause_index
//   o_out     out  valid/ready        removable, literal_echo, usage_state
//
// One item per cycle sustained while the output drains. The RAM read is
// launched at the acceptance edge; the item then waits in the modify stage,
// and modify, write back and the output register load happen as it advances.
// After reset a clearing pass writes every entry to none, with ready low throughout.
// A stalled output holds the item in the modify stage; the RAM read data is
// held by gating the read enable, so nothing is lost or repeated.
// Back-to-back items on the same variable take the written entry from the
// bypass register captured at acceptance instead of the stale RAM word.
`include "assert_macros.svh"

module variable_occurrence_table_core (
    input  logic i_clk,
    input  logic i_rst_n,
    vot_in_if.sink    i_in,
    vot_out_if.source o_out
);
    import vot_pkg::*;

    // ---------------- input decode ----------------
    logic [LIT_W-1:0] in_mag;
    logic             in_range;
    t_idx             in_idx;
    logic             in_acc;

    // magnitude of the signed literal; -2^16 yields 2^16 as unsigned
    assign in_mag   = i_in.literal[LIT_W-1] ? LIT_W'(~i_in.literal + 1'b1)
                                            : LIT_W'(i_in.literal);
    assign in_range = (32'(in_mag) < 32'(MAX_VARIABLES));
    assign in_idx   = IDX_W'(32'(in_mag));
    assign in_acc   = i_in.valid && i_in.ready;

    // ---------------- clearing pass ----------------
    logic r_clr_busy;
    t_idx r_clr_addr;

    // ---------------- modify stage ----------------
    logic             r_s1_valid;
    logic [CMD_W-1:0] r_s1_cmd;
    logic [LIT_W-1:0] r_s1_lit;
    t_clause          r_s1_clause;
    t_idx             r_s1_idx;
    logic             r_s1_range;
    logic             r_s1_nz;
    logic             r_s1_byp;
    t_entry           r_s1_byp_data;
    logic             n_s1_byp;

    // ---------------- output register ----------------
    logic             r_out_valid;
    logic             r_out_removable;
    logic [LIT_W-1:0] r_out_lit;
    t_usage           r_out_state;

    logic [ENTRY_W-1:0] ram_rdata;
    logic               ram_we;
    t_idx               ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;

    t_entry cur;
    t_entry nxt;
    logic   s1_removable;
    t_usage s1_state;
    logic   s1_adv;
    logic   s1_wr;

    // Advance the modify stage when the output register is free or drains now.
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign s1_wr      = s1_adv && r_s1_range;
    assign i_in.ready = !r_clr_busy && (!r_s1_valid || s1_adv);

    // Bypass when the entry being written back is the one being read now.
    assign n_s1_byp = s1_wr && (in_idx == r_s1_idx);

    // Entry as the previous item left it.
    assign cur = r_s1_byp ? r_s1_byp_data : t_entry'(ram_rdata);

    always_comb begin
        nxt          = cur;
        s1_removable = 1'b0;
        unique case (r_s1_cmd)
            CMD_RECORD: begin
                // literal zero is ignored by record
                if (r_s1_nz) begin
                    if (cur.st == ST_NONE) begin
                        nxt.st = ST_ONCE;
                        nxt.cl = r_s1_clause;
                    end else if (cur.st == ST_ONCE && cur.cl != r_s1_clause) begin
                        nxt.st = ST_MORE;
                        nxt.cl = r_s1_clause;
                    end
                end
            end
            CMD_QUERY: begin
                s1_removable = (cur.st != ST_MORE);
            end
            CMD_MARK: begin
                nxt.st = ST_MARK;
            end
            default: begin
                // unused command: hold the entry, report it
                nxt = cur;
            end
        endcase
        // variables beyond the table report none and are never removable
        s1_state = r_s1_range ? nxt.st : ST_NONE;
        if (!r_s1_range) begin
            s1_removable = 1'b0;
        end
    end

    // Clearing pass owns the write port right after reset.
    assign ram_we    = r_clr_busy || s1_wr;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_idx;
    assign ram_wdata = r_clr_busy ? '0 : ENTRY_W'(nxt);

    vot_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_VARIABLES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == IDX_W'(MAX_VARIABLES - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd      <= i_in.cmd;
            r_s1_lit      <= i_in.literal;
            r_s1_clause   <= CLAUSE_INDEX_BITS'(32'(i_in.clause_index));
            r_s1_idx      <= in_idx;
            r_s1_range    <= in_range;
            r_s1_nz       <= (in_mag != '0);
            r_s1_byp      <= n_s1_byp;
            r_s1_byp_data <= nxt;
        end
        if (s1_adv) begin
            r_out_removable <= s1_removable;
            r_out_lit       <= r_s1_lit;
            r_out_state     <= s1_state;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.removable    = r_out_removable;
    assign o_out.literal_echo = r_out_lit;
    assign o_out.usage_state  = r_out_state;

    // ---------------- assertions ----------------
    `VOT_ASSERT_ALWAYS(a_no_item_while_clearing, i_clk,
        !(r_clr_busy === 1'b1 && r_s1_valid === 1'b1), "item in pipeline during clearing pass")
    `VOT_ASSERT(a_bypass_taken, i_clk, i_rst_n,
        (s1_wr && in_acc && in_idx == r_s1_idx) |=> r_s1_byp, "same-entry item missed the bypass")
    `VOT_ASSERT(a_stage_drains, i_clk, i_rst_n,
        s1_adv |=> r_out_valid, "advanced item did not reach the output register")
    `VOT_ASSERT(a_more_not_removable, i_clk, i_rst_n,
        r_out_valid |-> !(r_out_removable && r_out_state == ST_MORE), "more-than-once removable")

endmodule

// ===== src/vot_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module vot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
